// ===== rtl/lipschitz_acceptance_test_assert.svh =====
// Assertion macros used by lipschitz_acceptance_test.sv.
`ifndef LIPSCHITZ_ACCEPTANCE_TEST_ASSERT_SVH
`define LIPSCHITZ_ACCEPTANCE_TEST_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LAT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/lat_pkg.sv =====
package lat_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int MAX_DIMS    = 16;
    localparam int SAMP_AW     = $clog2(MAX_SAMPLES);
    localparam int DIM_AW      = $clog2(MAX_DIMS);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int COORD_AW    = SAMP_AW + DIM_AW;
    localparam int DATA_W      = 32;
    localparam int DCFG_W      = 5;
    localparam int MUL_W       = 33;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int DSUM_W      = 68;
    localparam int ACC_W       = 132;

    typedef enum logic [1:0] {
        ACT_ADD     = 2'd0,
        ACT_QUERY   = 2'd1,
        ACT_RESTART = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        REG_DIMS     = 2'd0,
        REG_PATIENCE = 2'd1,
        REG_GROWTH   = 2'd2,
        REG_EPSSTART = 2'd3
    } t_reg;

endpackage

// ===== rtl/lat_ram.sv =====
module lat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/lat_mul.sv =====
module lat_mul (
    input  logic                        i_clk,
    input  logic [lat_pkg::MUL_W-1:0]   i_a,
    input  logic [lat_pkg::MUL_W-1:0]   i_b,
    output logic [lat_pkg::PROD_W-1:0]  o_prod
);

    always_ff @(posedge i_clk) begin
        o_prod <= i_a * i_b;
    end

endmodule

// ===== rtl/lipschitz_acceptance_test.sv =====
// Channel   Direction  Handshake                    Payload
// input     in         start high, busy low         i_action, i_coord, i_sample_value
// result    out        o_valid, one cycle           o_accepted, o_eps_now, o_store_full
// config    in/out     APB psel/penable/pwrite      paddr, pwdata, prdata
// Add, restart and non-final query coordinates complete without raising busy.
// The final query coordinate walks the stored samples with one shared 33x33 multiplier.
// The walk stops at the first failing sample, and o_valid rises as busy falls.
// Reset is synchronous and active low; sample memories need no clearing.
// The result strobe lasts one cycle and the receiver cannot stall it.
`include "lipschitz_acceptance_test_assert.svh"

module lipschitz_acceptance_test (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_action,
    input  logic signed [31:0]          i_coord,
    input  logic signed [31:0]          i_sample_value,
    output logic                        o_valid,
    output logic                        o_accepted,
    output logic [31:0]                 o_eps_now,
    output logic                        o_store_full,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [3:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_GRM, S_GRW, S_E2M, S_E2W, S_RD, S_DIF,
        S_ACC, S_GAP, S_LSQ, S_PPM, S_PPA, S_CMP
    } t_state;

    t_state r_state;
    logic [lat_pkg::DCFG_W-1:0]   r_dims_cfg;
    logic [15:0]                  r_patience;
    logic [23:0]                  r_growth;
    logic [31:0]                  r_eps_start;
    logic [lat_pkg::CNT_W-1:0]    r_count;
    logic signed [31:0]           r_max;
    logic [lat_pkg::DIM_AW-1:0]   r_pos;
    logic [31:0]                  r_eps;
    logic [15:0]                  r_last;
    logic [15:0]                  r_wait;
    logic                         r_drop;
    logic                         r_post;
    logic [lat_pkg::SAMP_AW-1:0]  r_i;
    logic [lat_pkg::DIM_AW-1:0]   r_k;
    logic [2:0]                   r_pp;
    logic [63:0]                  r_e2;
    logic [63:0]                  r_lsq;
    logic [lat_pkg::DSUM_W-1:0]   r_dsum;
    logic [lat_pkg::ACC_W-1:0]    r_acc;
    logic signed [31:0]           r_query [lat_pkg::MAX_DIMS];

    logic [lat_pkg::DIM_AW:0]     dims;
    logic [lat_pkg::DIM_AW-1:0]   pos_eff;
    logic                         last;
    logic                         accept;
    logic                         room;
    logic                         cfg_wr;
    logic [lat_pkg::MUL_W-1:0]    mul_a;
    logic [lat_pkg::MUL_W-1:0]    mul_b;
    logic [lat_pkg::PROD_W-1:0]   prod;
    logic [31:0]                  coord_rd;
    logic [31:0]                  value_rd;
    logic                         coord_we;
    logic                         value_we;
    logic signed [32:0]           diff;
    logic [32:0]                  gap;
    logic [31:0]                  eps_grown;
    logic [15:0]                  wait_inc;
    logic [lat_pkg::ACC_W-1:0]    pp_shifted;
    logic [lat_pkg::ACC_W-1:0]    lhs;
    logic [1:0]                   pp_shift;
    logic [31:0]                  e_limb;
    logic [31:0]                  d_limb;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign room   = (r_count < lat_pkg::CNT_W'(lat_pkg::MAX_SAMPLES));

    always_comb begin
        if (r_dims_cfg == '0) begin
            dims = (lat_pkg::DIM_AW + 1)'(1);
        end else if (32'(r_dims_cfg) > lat_pkg::MAX_DIMS) begin
            dims = (lat_pkg::DIM_AW + 1)'(lat_pkg::MAX_DIMS);
        end else begin
            dims = (lat_pkg::DIM_AW + 1)'(r_dims_cfg);
        end
        if ({1'b0, r_pos} >= dims) begin
            pos_eff = lat_pkg::DIM_AW'(dims - 1'b1);
        end else begin
            pos_eff = r_pos;
        end
        last = (({1'b0, pos_eff} + 1'b1) == dims);
    end

    always_comb begin
        unique case (lat_pkg::t_reg'(paddr[3:2]))
            lat_pkg::REG_DIMS:     prdata = 32'(r_dims_cfg);
            lat_pkg::REG_PATIENCE: prdata = 32'(r_patience);
            lat_pkg::REG_GROWTH:   prdata = 32'(r_growth);
            lat_pkg::REG_EPSSTART: prdata = r_eps_start;
            default:               prdata = '0;
        endcase
    end

    assign coord_we = accept && (lat_pkg::t_action'(i_action) == lat_pkg::ACT_ADD) && room;
    assign value_we = coord_we && last;

    lat_ram #(.WIDTH(lat_pkg::DATA_W), .DEPTH(lat_pkg::MAX_SAMPLES * lat_pkg::MAX_DIMS))
    u_coord_ram (
        .i_clk   (i_clk),
        .i_we    (coord_we),
        .i_waddr ({r_count[lat_pkg::SAMP_AW-1:0], pos_eff}),
        .i_wdata (i_coord),
        .i_raddr ({r_i, r_k}),
        .o_rdata (coord_rd)
    );

    lat_ram #(.WIDTH(lat_pkg::DATA_W), .DEPTH(lat_pkg::MAX_SAMPLES)) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (value_we),
        .i_waddr (r_count[lat_pkg::SAMP_AW-1:0]),
        .i_wdata (i_sample_value),
        .i_raddr (r_i),
        .o_rdata (value_rd)
    );

    lat_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    always_comb begin
        diff     = {r_query[r_k][31], r_query[r_k]} - {coord_rd[31], coord_rd};
        gap      = {r_max[31], r_max} - {value_rd[31], value_rd};
        e_limb   = r_pp[0] ? r_e2[63:32] : r_e2[31:0];
        case (r_pp[2:1])
            2'd0:    d_limb = r_dsum[31:0];
            2'd1:    d_limb = r_dsum[63:32];
            default: d_limb = 32'(r_dsum[lat_pkg::DSUM_W-1:64]);
        endcase
        pp_shift = 2'(r_pp[2:1]) + 2'(r_pp[0]);
        case (pp_shift)
            2'd0:    pp_shifted = lat_pkg::ACC_W'(prod);
            2'd1:    pp_shifted = lat_pkg::ACC_W'(prod) << 32;
            2'd2:    pp_shifted = lat_pkg::ACC_W'(prod) << 64;
            default: pp_shifted = lat_pkg::ACC_W'(prod) << 96;
        endcase
        lhs = lat_pkg::ACC_W'({r_lsq, 32'h0});
        if (prod[lat_pkg::PROD_W-1:48] != '0) begin
            eps_grown = 32'hFFFF_FFFF;
        end else begin
            eps_grown = prod[47:16];
        end
        wait_inc = (r_wait == 16'hFFFF) ? r_wait : r_wait + 16'd1;
        case (r_state)
            S_GRM: begin
                mul_a = 33'(r_eps);
                mul_b = 33'(r_growth);
            end
            S_E2M: begin
                mul_a = 33'(r_eps);
                mul_b = 33'(r_eps);
            end
            S_DIF: begin
                mul_a = diff[32] ? 33'(-diff) : 33'(diff);
                mul_b = diff[32] ? 33'(-diff) : 33'(diff);
            end
            S_GAP: begin
                mul_a = gap;
                mul_b = gap;
            end
            default: begin
                mul_a = 33'(e_limb);
                mul_b = 33'(d_limb);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dims_cfg  <= 5'd2;
            r_patience  <= 16'd1000;
            r_growth    <= 24'd65602;
            r_eps_start <= 32'd655;
            r_count     <= '0;
            r_max       <= 32'sh8000_0000;
            r_pos       <= '0;
            r_eps       <= 32'd655;
            r_last      <= 16'd1;
            r_wait      <= '0;
            r_drop      <= 1'b0;
            r_post      <= 1'b0;
            for (int k = 0; k < lat_pkg::MAX_DIMS; k++) begin
                r_query[k] <= '0;
            end
            o_valid     <= 1'b0;
            o_accepted  <= 1'b0;
            o_eps_now   <= '0;
            o_store_full <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (cfg_wr) begin
                unique case (lat_pkg::t_reg'(paddr[3:2]))
                    lat_pkg::REG_DIMS:     r_dims_cfg  <= pwdata[lat_pkg::DCFG_W-1:0];
                    lat_pkg::REG_PATIENCE: r_patience  <= pwdata[15:0];
                    lat_pkg::REG_GROWTH:   r_growth    <= pwdata[23:0];
                    lat_pkg::REG_EPSSTART: r_eps_start <= pwdata;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (lat_pkg::t_action'(i_action))
                            lat_pkg::ACT_RESTART: begin
                                r_count <= '0;
                                r_max   <= 32'sh8000_0000;
                                r_pos   <= '0;
                                r_eps   <= r_eps_start;
                                r_last  <= 16'd1;
                                r_wait  <= '0;
                                r_drop  <= 1'b0;
                                for (int k = 0; k < lat_pkg::MAX_DIMS; k++) begin
                                    r_query[k] <= '0;
                                end
                            end
                            lat_pkg::ACT_ADD: begin
                                r_pos <= last ? '0 : pos_eff + 1'b1;
                                if (last) begin
                                    if (room) begin
                                        r_count <= r_count + 1'b1;
                                        if (i_sample_value > r_max) begin
                                            r_max <= i_sample_value;
                                        end
                                    end else begin
                                        r_drop <= 1'b1;
                                    end
                                end
                            end
                            lat_pkg::ACT_QUERY: begin
                                r_pos <= last ? '0 : pos_eff + 1'b1;
                                if (pos_eff == '0) begin
                                    for (int k = 1; k < lat_pkg::MAX_DIMS; k++) begin
                                        r_query[k] <= '0;
                                    end
                                end
                                r_query[pos_eff] <= i_coord;
                                if (last) begin
                                    if (r_count == '0) begin
                                        o_valid      <= 1'b1;
                                        o_accepted   <= 1'b1;
                                        o_eps_now    <= r_eps;
                                        o_store_full <= r_drop;
                                    end else begin
                                        r_wait  <= wait_inc;
                                        r_state <= S_CHK;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_CHK: begin
                    r_post <= 1'b0;
                    if ({2'b0, r_wait} > ({2'b0, r_last} + {2'b0, r_patience})) begin
                        r_state <= S_GRM;
                    end else begin
                        r_state <= S_E2M;
                    end
                end
                S_GRM: r_state <= S_GRW;
                S_GRW: begin
                    r_eps  <= eps_grown;
                    r_wait <= '0;
                    if (r_post) begin
                        o_valid      <= 1'b1;
                        o_accepted   <= 1'b1;
                        o_eps_now    <= eps_grown;
                        o_store_full <= r_drop;
                        r_state      <= S_IDLE;
                    end else begin
                        r_state <= S_E2M;
                    end
                end
                S_E2M: r_state <= S_E2W;
                S_E2W: begin
                    r_e2    <= prod[63:0];
                    r_i     <= '0;
                    r_k     <= '0;
                    r_dsum  <= '0;
                    r_state <= S_RD;
                end
                S_RD:  r_state <= S_DIF;
                S_DIF: r_state <= S_ACC;
                S_ACC: begin
                    r_dsum <= r_dsum + lat_pkg::DSUM_W'(prod);
                    if (({1'b0, r_k} + 1'b1) == dims) begin
                        r_state <= S_GAP;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_GAP: r_state <= S_LSQ;
                S_LSQ: begin
                    r_lsq   <= prod[63:0];
                    r_acc   <= '0;
                    r_pp    <= '0;
                    r_state <= S_PPM;
                end
                S_PPM: r_state <= S_PPA;
                S_PPA: begin
                    r_acc <= r_acc + pp_shifted;
                    if (r_pp == 3'd5) begin
                        r_state <= S_CMP;
                    end else begin
                        r_pp    <= r_pp + 3'd1;
                        r_state <= S_PPM;
                    end
                end
                S_CMP: begin
                    if (lhs > r_acc) begin
                        o_valid      <= 1'b1;
                        o_accepted   <= 1'b0;
                        o_eps_now    <= r_eps;
                        o_store_full <= r_drop;
                        r_state      <= S_IDLE;
                    end else if (({1'b0, r_i} + 1'b1) == r_count) begin
                        r_last  <= r_wait;
                        r_post  <= 1'b1;
                        r_state <= S_GRM;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_k     <= '0;
                        r_dsum  <= '0;
                        r_state <= S_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `LAT_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= lat_pkg::CNT_W'(lat_pkg::MAX_SAMPLES))
    `LAT_ASSERT_NEXT(a_count_stable_busy, i_clk, i_rst_n, busy, $stable(r_count))
    `LAT_ASSERT_SAME(a_walk_index, i_clk, i_rst_n, r_state == S_RD,
        ({1'b0, r_i} < r_count) && (({1'b0, r_k}) < dims))

endmodule
